FILE: sv/avcc_pkg.sv
package avcc_pkg;

  localparam int PS_DEPTH_DEF = 256;

  localparam logic [2:0] LEN_BYTES_RST = 3'd4;
  localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_STREAM    = 2'd1,
    OP_PS_APPEND = 2'd2,
    OP_PS_CLEAR  = 2'd3
  } op_t;

  localparam logic [4:0] NAL_NON_IDR = 5'd1;
  localparam logic [4:0] NAL_IDR     = 5'd5;
  localparam logic [4:0] NAL_SPS     = 5'd7;
  localparam logic [4:0] NAL_PPS     = 5'd8;
  localparam logic [4:0] NAL_AUD     = 5'd9;

  // access unit delimiter 00 00 00 01 09 f0, first byte in the low bits
  localparam logic [63:0] AUD_WORD  = 64'h0000_f009_0100_0000;
  localparam logic [3:0]  AUD_COUNT = 4'd6;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } res_t;

endpackage

FILE: sv/avcc_in_if.sv
interface avcc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       key_flag;
  logic       chunk_last;

  modport source (output valid, output opcode, output data_byte, output key_flag,
                  output chunk_last, input ready);
  modport sink (input valid, input opcode, input data_byte, input key_flag,
                input chunk_last, output ready);
endinterface

FILE: sv/avcc_out_if.sv
interface avcc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output out_bytes, output byte_count, output last,
                  input ready);
  modport sink (input valid, input out_bytes, input byte_count, input last,
                output ready);
endinterface

FILE: sv/avcc_ps_mem.sv
module avcc_ps_mem #(
  parameter int PS_ROWS = 32,
  localparam int ROW_W = (PS_ROWS > 1) ? $clog2(PS_ROWS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] wrow,
  input  logic [2:0]       wcol,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ROW_W-1:0] rrow,
  output logic [63:0]      rdata
);

  logic [63:0] mem [PS_ROWS];

  // byte-wide writes, row-wide reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wrow][{wcol, 3'b000} +: 8] <= wdata;
    end
    if (re) begin
      rdata <= mem[rrow];
    end
  end

endmodule

FILE: sv/avcc_parser.sv
module avcc_parser #(
  parameter int PS_DEPTH = avcc_pkg::PS_DEPTH_DEF,
  localparam int CNT_W = $clog2(PS_DEPTH + 1),
  localparam int PS_ROWS = (PS_DEPTH + 7) / 8,
  localparam int ROW_W = (PS_ROWS > 1) ? $clog2(PS_ROWS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        length_field_bytes,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_data,
  input  logic              in_key,
  output logic              res_valid,
  input  logic              res_ready,
  output avcc_pkg::res_t    res,
  output logic              mem_we,
  output logic [ROW_W-1:0]  mem_wrow,
  output logic [2:0]        mem_wcol,
  output logic [7:0]        mem_wdata,
  output logic              mem_re,
  output logic [ROW_W-1:0]  mem_rrow,
  input  logic [63:0]       mem_rdata
);
  import avcc_pkg::*;

  typedef enum logic [3:0] {
    PH_LENGTH = 4'b0001,
    PH_TYPE   = 4'b0010,
    PH_COPY   = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PS_RD   = 4'b0010,
    ST_PS_WAIT = 4'b0100,
    ST_SC      = 4'b1000
  } st_t;

  function automatic logic [2:0] prefix_len(input logic [2:0] cfg);
    logic [2:0] len;
    if (cfg == 3'd0) begin
      len = 3'd1;
    end else if (cfg > LEN_BYTES_MAX) begin
      len = LEN_BYTES_MAX;
    end else begin
      len = cfg;
    end
    return len;
  endfunction

  function automatic res_t sc_result(input logic first, input logic [7:0] nal_hdr);
    res_t r;
    if (first) begin
      r.out_bytes  = {24'h0, nal_hdr, 8'h01, 8'h00, 8'h00, 8'h00};
      r.byte_count = 4'd5;
    end else begin
      r.out_bytes  = {32'h0, nal_hdr, 8'h01, 8'h00, 8'h00};
      r.byte_count = 4'd4;
    end
    r.last = 1'b1;
    return r;
  endfunction

  st_t             state, state_next;
  phase_t          phase, phase_next;
  logic [2:0]      len_left, len_left_next;
  logic [31:0]     nal_left, nal_left_next;
  logic            first_nal, first_nal_next;
  logic            frame_key, frame_key_next;
  logic            sets_pending, sets_pending_next;
  logic [CNT_W-1:0] ps_count, ps_count_next;
  logic [CNT_W-1:0] ps_left, ps_left_next;
  logic [ROW_W-1:0] ps_row, ps_row_next;
  logic            sc_first, sc_first_next;
  logic [7:0]      sc_byte, sc_byte_next;

  logic        acc;
  logic [31:0] nal_shift;
  logic [31:0] nal_dec;
  logic [4:0]  nal_type;
  logic        emit_sets;
  logic [3:0]  row_cnt;

  assign in_ready  = (state == ST_IDLE) && res_ready;
  assign acc       = in_valid && in_ready;
  assign nal_shift = {nal_left[23:0], in_data};
  assign nal_dec   = nal_left - 32'd1;
  assign nal_type  = in_data[4:0];
  assign emit_sets = ((nal_type == NAL_IDR) || (nal_type == NAL_SPS) ||
                      (nal_type == NAL_PPS)) && frame_key && sets_pending;
  assign row_cnt   = (ps_left > CNT_W'(8)) ? 4'd8 : ps_left[3:0];

  assign mem_wrow  = ps_count[ROW_W+2:3];
  assign mem_wcol  = ps_count[2:0];
  assign mem_wdata = in_data;
  assign mem_rrow  = ps_row;

  always_comb begin
    state_next        = state;
    phase_next        = phase;
    len_left_next     = len_left;
    nal_left_next     = nal_left;
    first_nal_next    = first_nal;
    frame_key_next    = frame_key;
    sets_pending_next = sets_pending;
    ps_count_next     = ps_count;
    ps_left_next      = ps_left;
    ps_row_next       = ps_row;
    sc_first_next     = sc_first;
    sc_byte_next      = sc_byte;
    res_valid         = 1'b0;
    res               = '0;
    mem_we            = 1'b0;
    mem_re            = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (op_t'(in_opcode))
            OP_FRAME: begin
              phase_next     = PH_LENGTH;
              len_left_next  = prefix_len(length_field_bytes);
              nal_left_next  = '0;
              first_nal_next = 1'b1;
              frame_key_next = in_key;
              res_valid      = 1'b1;
              res.out_bytes  = AUD_WORD;
              res.byte_count = AUD_COUNT;
              res.last       = 1'b1;
            end
            OP_PS_APPEND: begin
              if (ps_count < CNT_W'(PS_DEPTH)) begin
                mem_we        = 1'b1;
                ps_count_next = ps_count + 1'b1;
              end
            end
            OP_PS_CLEAR: begin
              ps_count_next = '0;
            end
            OP_STREAM: begin
              unique case (phase)
                PH_LENGTH: begin
                  nal_left_next = nal_shift;
                  if (len_left <= 3'd1) begin
                    if (nal_shift == 32'd0) begin
                      len_left_next = prefix_len(length_field_bytes);
                    end else begin
                      phase_next = PH_TYPE;
                    end
                  end else begin
                    len_left_next = len_left - 3'd1;
                  end
                end
                PH_TYPE: begin
                  if (nal_type == NAL_AUD) begin
                    phase_next = PH_SKIP;
                  end else begin
                    if (nal_type == NAL_NON_IDR) begin
                      sets_pending_next = 1'b1;
                    end
                    first_nal_next = 1'b0;
                    phase_next     = PH_COPY;
                    if (emit_sets) begin
                      sets_pending_next = 1'b0;
                    end
                    if (emit_sets && (ps_count != '0)) begin
                      state_next    = ST_PS_RD;
                      ps_left_next  = ps_count;
                      ps_row_next   = '0;
                      sc_first_next = first_nal;
                      sc_byte_next  = in_data;
                    end else begin
                      res_valid = 1'b1;
                      res       = sc_result(first_nal, in_data);
                    end
                  end
                  nal_left_next = nal_dec;
                  if (nal_dec == 32'd0) begin
                    phase_next    = PH_LENGTH;
                    len_left_next = prefix_len(length_field_bytes);
                  end
                end
                PH_COPY, PH_SKIP: begin
                  if (phase == PH_COPY) begin
                    res_valid      = 1'b1;
                    res.out_bytes  = {56'h0, in_data};
                    res.byte_count = 4'd1;
                    res.last       = 1'b1;
                  end
                  nal_left_next = nal_dec;
                  if (nal_dec == 32'd0) begin
                    phase_next    = PH_LENGTH;
                    len_left_next = prefix_len(length_field_bytes);
                  end
                end
                default: begin
                  phase_next    = PH_LENGTH;
                  len_left_next = prefix_len(length_field_bytes);
                  nal_left_next = '0;
                end
              endcase
            end
          endcase
        end
      end
      ST_PS_RD: begin
        mem_re     = 1'b1;
        state_next = ST_PS_WAIT;
      end
      ST_PS_WAIT: begin
        if (res_ready) begin
          res_valid = 1'b1;
          for (int k = 0; k < 8; k++) begin
            if (4'(k) < row_cnt) begin
              res.out_bytes[8*k +: 8] = mem_rdata[8*k +: 8];
            end
          end
          res.byte_count = row_cnt;
          res.last       = 1'b0;
          ps_left_next   = ps_left - CNT_W'(row_cnt);
          ps_row_next    = ps_row + 1'b1;
          if (ps_left <= CNT_W'(8)) begin
            state_next = ST_SC;
          end else begin
            state_next = ST_PS_RD;
          end
        end
      end
      ST_SC: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          res        = sc_result(sc_first, sc_byte);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_LENGTH;
      len_left     <= LEN_BYTES_RST;
      nal_left     <= '0;
      first_nal    <= 1'b1;
      frame_key    <= 1'b0;
      sets_pending <= 1'b1;
      ps_count     <= '0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      len_left     <= len_left_next;
      nal_left     <= nal_left_next;
      first_nal    <= first_nal_next;
      frame_key    <= frame_key_next;
      sets_pending <= sets_pending_next;
      ps_count     <= ps_count_next;
    end
  end

  always_ff @(posedge clk) begin
    ps_left  <= ps_left_next;
    ps_row   <= ps_row_next;
    sc_first <= sc_first_next;
    sc_byte  <= sc_byte_next;
  end

endmodule

FILE: sv/avcc_to_annexb_converter_top.sv
// Turns length-prefixed H.264 NAL units into start-code form, one input byte per transfer.
// Frame-start, stream, parameter-set append and clear items are each taken while the parser
// is idle and the output register is free or being emptied. The first IDR, SPS or PPS NAL of
// a key frame with parameter sets pending replays the parameter-set store ahead of its start
// code: the store has one 8-byte read port with a registered read, so that item holds the
// input while each 8-byte row is read and then sent, and then while the start code is sent.
// Output back-pressure adds its own stall cycles. The length prefix size (1 to 4 bytes) is
// written through cfg_wr_en/cfg_wr_data and applies from the next length field onward.
module avcc_to_annexb_converter_top #(
  parameter int PS_DEPTH = avcc_pkg::PS_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_wr_data,
  avcc_in_if.sink           in_ch,
  avcc_out_if.source        out_ch
);
  import avcc_pkg::*;

  localparam int PS_ROWS = (PS_DEPTH + 7) / 8;
  localparam int ROW_W = (PS_ROWS > 1) ? $clog2(PS_ROWS) : 1;

  logic [2:0]       length_field_bytes;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_reg;
  logic             out_valid;
  logic             mem_we;
  logic [ROW_W-1:0] mem_wrow;
  logic [2:0]       mem_wcol;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [ROW_W-1:0] mem_rrow;
  logic [63:0]      mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_field_bytes <= LEN_BYTES_RST;
    end else if (cfg_wr_en) begin
      length_field_bytes <= cfg_wr_data;
    end
  end

  avcc_parser #(
    .PS_DEPTH (PS_DEPTH)
  ) u_parser (
    .clk                (clk),
    .rst                (rst),
    .length_field_bytes (length_field_bytes),
    .in_valid           (in_ch.valid),
    .in_ready           (in_ch.ready),
    .in_opcode          (in_ch.opcode),
    .in_data            (in_ch.data_byte),
    .in_key             (in_ch.key_flag),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res                (res),
    .mem_we             (mem_we),
    .mem_wrow           (mem_wrow),
    .mem_wcol           (mem_wcol),
    .mem_wdata          (mem_wdata),
    .mem_re             (mem_re),
    .mem_rrow           (mem_rrow),
    .mem_rdata          (mem_rdata)
  );

  avcc_ps_mem #(
    .PS_ROWS (PS_ROWS)
  ) u_ps_mem (
    .clk   (clk),
    .we    (mem_we),
    .wrow  (mem_wrow),
    .wcol  (mem_wcol),
    .wdata (mem_wdata),
    .re    (mem_re),
    .rrow  (mem_rrow),
    .rdata (mem_rdata)
  );

  // output register, refilled in the cycle it drains
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_bytes  = out_reg.out_bytes;
  assign out_ch.byte_count = out_reg.byte_count;
  assign out_ch.last       = out_reg.last;

endmodule

FILE: sv/avcc_checker.sv
module avcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic        last
);
  import avcc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes) &&
      $stable(byte_count) && $stable(last))
    else $error("output changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
    else $error("byte_count out of range");

  // frame start gives the delimiter in the next cycle
  a_frame_aud: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode == OP_FRAME) |=>
      out_valid && last && (byte_count == AUD_COUNT) && (out_bytes == AUD_WORD))
    else $error("frame start without delimiter");

  // no new transfer while a parameter-set replay is in flight
  a_busy_replay: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken during parameter-set replay");

endmodule

bind avcc_to_annexb_converter_top avcc_checker u_avcc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_bytes  (out_ch.out_bytes),
  .byte_count (out_ch.byte_count),
  .last       (out_ch.last)
);
